>>> rtl/core/table_linear_and_binary_search_macros.svh
// Assertion macros used by the module of the table search block.
// They expect signals named clk and rst_n in the module that uses them.
`ifndef TABLE_LINEAR_AND_BINARY_SEARCH_MACROS_SVH
`define TABLE_LINEAR_AND_BINARY_SEARCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tls_pkg.sv
package tls_pkg;

  localparam int KEY_W = 32;
  localparam int CMD_W = 2;
  localparam int POS_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_LINEAR = 2'd1,
    CMD_BINARY = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIN,
    ST_BADDR,
    ST_BCMP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

>>> rtl/core/tls_if.sv
interface tls_in_if;
  import tls_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [KEY_W-1:0] key_value;

  modport source (output valid, output command, output key_value, input ready);
  modport sink   (input valid, input command, input key_value, output ready);
endinterface

interface tls_out_if;
  import tls_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;
  logic             status;

  modport source (output valid, output found, output position, output status, input ready);
  modport sink   (input valid, input found, input position, input status, output ready);
endinterface

>>> rtl/core/tls_ram.sv
module tls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/tls_cmp.sv
module tls_cmp (
  input  logic signed [tls_pkg::KEY_W-1:0] key,
  input  logic signed [tls_pkg::KEY_W-1:0] entry,
  output tls_pkg::cmp_res_t                res
);
  import tls_pkg::*;

  always_comb begin
    res.eq = (key == entry);
    res.lt = (key < entry);
  end

endmodule

>>> rtl/core/table_linear_and_binary_search.sv
// Table of signed 32-bit entries with append, clear, linear and binary search.
// Input channel in_ch carries one command and a key or value per beat; the
// result channel out_ch returns exactly one beat (found, position, status)
// for each input beat, in order.
// The block takes one command at a time: in_ch.ready is high only while idle.
// Append and clear finish in the cycle that accepts them; the result is offered in the cycle after.
// Linear search reads one entry per cycle from the table RAM through the
// shared comparator.
// Binary search runs each probe as an address step (ST_BADDR), then a
// compare step (ST_BCMP).
// Position is the matched or written index modulo 256.
// Reset empties the table at once; old contents are never read again.
// A result that is not taken stays on out_ch, and no new beat is accepted
// until the receiver raises out_ch.ready.
`include "table_linear_and_binary_search_macros.svh"

module table_linear_and_binary_search #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  tls_in_if.sink           in_ch,
  tls_out_if.source        out_ch
);
  import tls_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic [AW-1:0]           lo_r, lo_nxt;
  logic [AW-1:0]           hi_r, hi_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic                    found_r, found_nxt;
  logic [POS_W-1:0]        position_r, position_nxt;
  logic                    status_r, status_nxt;

  logic                    ram_we;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [KEY_W-1:0]        ram_rdata;
  cmp_res_t                cmp_res;
  logic [AW:0]             mid_sum;
  logic [CW-1:0]           idx_inc;
  logic [CW-1:0]           count_dec;
  logic [AW+POS_W-1:0]     idx_ext;
  logic [CW+POS_W-1:0]     count_ext;

  tls_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_ch.key_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tls_cmp u_cmp (
    .key   (key_r),
    .entry ($signed(ram_rdata)),
    .res   (cmp_res)
  );

  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign idx_inc   = CW'(idx_r) + CW'(1);
  assign count_dec = count_r - CW'(1);
  assign idx_ext   = (AW + POS_W)'(idx_r);
  assign count_ext = (CW + POS_W)'(count_r);

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign out_ch.valid    = (state_r == ST_OUT);
  assign out_ch.found    = found_r;
  assign out_ch.position = position_r;
  assign out_ch.status   = status_r;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    key_nxt      = key_r;
    found_nxt    = found_r;
    position_nxt = position_r;
    status_nxt   = status_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          key_nxt      = in_ch.key_value;
          found_nxt    = 1'b0;
          position_nxt = '0;
          status_nxt   = 1'b0;
          state_nxt    = ST_OUT;
          case (cmd_t'(in_ch.command))
            CMD_APPEND: begin
              if (count_r != CW'(TABLE_DEPTH)) begin
                ram_we       = 1'b1;
                count_nxt    = count_r + CW'(1);
                position_nxt = count_ext[POS_W-1:0];
              end else begin
                status_nxt = 1'b1;
              end
            end
            CMD_LINEAR: begin
              if (count_r != '0) begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_nxt   = '0;
                state_nxt = ST_LIN;
              end
            end
            CMD_BINARY: begin
              if (count_r != '0) begin
                lo_nxt    = '0;
                hi_nxt    = count_dec[AW-1:0];
                state_nxt = ST_BADDR;
              end
            end
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              state_nxt = ST_OUT;
            end
          endcase
        end
      end
      ST_LIN: begin
        if (cmp_res.eq) begin
          found_nxt    = 1'b1;
          position_nxt = idx_ext[POS_W-1:0];
          state_nxt    = ST_OUT;
        end else if (idx_inc == count_r) begin
          state_nxt = ST_OUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_r + AW'(1);
          idx_nxt   = idx_r + AW'(1);
        end
      end
      ST_BADDR: begin
        ram_re    = 1'b1;
        ram_raddr = mid_sum[AW:1];
        idx_nxt   = mid_sum[AW:1];
        state_nxt = ST_BCMP;
      end
      ST_BCMP: begin
        if (cmp_res.eq) begin
          found_nxt    = 1'b1;
          position_nxt = idx_ext[POS_W-1:0];
          state_nxt    = ST_OUT;
        end else if (cmp_res.lt) begin
          if (idx_r == lo_r) begin
            state_nxt = ST_OUT;
          end else begin
            hi_nxt    = idx_r - AW'(1);
            state_nxt = ST_BADDR;
          end
        end else begin
          if (idx_r == hi_r) begin
            state_nxt = ST_OUT;
          end else begin
            lo_nxt    = idx_r + AW'(1);
            state_nxt = ST_BADDR;
          end
        end
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    key_r      <= key_nxt;
    found_r    <= found_nxt;
    position_r <= position_nxt;
    status_r   <= status_nxt;
  end

  `TLS_ASSERT_SAME(a_ready_excl, in_ch.ready, !out_ch.valid, "input ready while result pending")
  `TLS_ASSERT_SAME(a_count_max, 1'b1, count_r <= CW'(TABLE_DEPTH), "entry count above depth")
  `TLS_ASSERT_SAME(a_lin_range, state_r == ST_LIN, CW'(idx_r) < count_r, "linear index out of range")
  `TLS_ASSERT_SAME(a_bin_range, state_r == ST_BCMP, (lo_r <= idx_r) && (idx_r <= hi_r), "probe outside range")
  `TLS_ASSERT_NEXT(a_clear, in_ch.valid && in_ch.ready && (in_ch.command == CMD_CLEAR), count_r == '0, "clear left entries")
  `TLS_ASSERT_NEXT(a_append, in_ch.valid && in_ch.ready && (in_ch.command == CMD_APPEND) && (count_r != CW'(TABLE_DEPTH)), count_r == $past(count_r) + CW'(1), "append did not count")

endmodule
